FILE: sv/prd_pkg.sv
package prd_pkg;

    // Default sizes handed to the top level parameters
    localparam int SIZE_BITS_DEF    = 24;
    localparam int PIX_PER_RES_DEF  = 4;

    // Fixed widths of the image size register and the result slots
    localparam int IMG_W            = 24;
    localparam int SLOTS            = 4;
    localparam int MAX_RESULTS      = 32;
    localparam int RES_IDX_W        = $clog2(MAX_RESULTS);

    // APB register map
    localparam int ADDR_W           = 3;
    localparam logic REG_RGBA       = 1'b0;
    localparam logic REG_IMAGE      = 1'b1;

    // Packet phase codes
    localparam logic [1:0] PH_COUNT = 2'd0;
    localparam logic [1:0] PH_RUN   = 2'd1;
    localparam logic [1:0] PH_LIT   = 2'd2;

    // Coded stream beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_last;
    } in_t;

    // Decoded pixel beat
    typedef struct packed {
        logic [31:0] pixel_a;
        logic [31:0] pixel_b;
        logic [31:0] pixel_c;
        logic [31:0] pixel_d;
        logic [2:0]  pixel_count;
        logic        corrupt;
        logic        image_full;
        logic        run_last;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic cap;   // latch accepted byte
        logic proc;  // decode latched byte, load burst
        logic emit;  // push one result into output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic emit_last;  // current result is the last of this byte
        logic out_busy;   // output register holds a beat
    } sts_t;

endpackage

FILE: sv/pixdata_rle_decoder.sv
// Channel      | Dir | Handshake                 | Beat
// -------------+-----+---------------------------+------------------------------
// byte         | in  | byte_valid / byte_ready   | one coded byte + stream_last
// pix          | out | pix_valid / pix_ready     | up to four pixels + flags
// apb          | in  | psel, penable, pwrite     | rgba_mode @0, image_bytes @4
//
// Each byte is decoded in S_PROC, then its result beats are loaded into the
// output register in S_EMIT; the next byte is taken with the last result beat.
// A completed run gives up to 32 result beats, one per cycle unless the
// output register stalls; a byte gives max(1, ceil(pixels / PIXELS_PER_RESULT))
// result beats, at most 32.
// Reset clears stream state, output valid, rgba_mode = 0, image_bytes = 1.
module pixdata_rle_decoder
#(
    parameter int SIZE_BITS         = prd_pkg::SIZE_BITS_DEF,
    parameter int PIXELS_PER_RESULT = prd_pkg::PIX_PER_RES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       byte_valid,
    output logic                       byte_ready,
    input  prd_pkg::in_t               byte_data,
    output logic                       pix_valid,
    input  logic                       pix_ready,
    output prd_pkg::out_t              pix_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [prd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int CNT_W = (SIZE_BITS < prd_pkg::IMG_W) ? SIZE_BITS : prd_pkg::IMG_W;

    logic             rgba_reg;
    logic [CNT_W-1:0] image_reg;
    logic             wr_en;
    logic             reg_sel;
    prd_pkg::cmd_t    cmd;
    prd_pkg::sts_t    sts;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgba_reg  <= 1'b0;
            image_reg <= CNT_W'(1);
        end
        else if (wr_en)
        begin
            case (reg_sel)
                prd_pkg::REG_RGBA:  rgba_reg  <= pwdata[0];
                prd_pkg::REG_IMAGE: image_reg <= pwdata[CNT_W-1:0];
                default:            rgba_reg  <= rgba_reg;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (reg_sel)
            prd_pkg::REG_RGBA:  prdata = {31'd0, rgba_reg};
            prd_pkg::REG_IMAGE: prdata = 32'(image_reg);
            default:            prdata = 32'd0;
        endcase
    end

    prd_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .pix_ready  (pix_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    prd_dp
    #(
        .SIZE_BITS         (SIZE_BITS),
        .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .byte_data   (byte_data),
        .rgba_mode   (rgba_reg),
        .image_bytes (image_reg),
        .pix_ready   (pix_ready),
        .pix_valid   (pix_valid),
        .pix_data    (pix_data)
    );

endmodule

FILE: sv/prd_ctrl.sv
module prd_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_valid,
    output logic          byte_ready,
    input  logic          pix_ready,
    input  prd_pkg::sts_t sts,
    output prd_pkg::cmd_t cmd
);

    localparam logic [1:0] S_WAIT = 2'd0;
    localparam logic [1:0] S_PROC = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       fire;
    logic       accept;

    // Output slot free or being drained this cycle
    assign fire       = (state_reg == S_EMIT) && (!sts.out_busy || pix_ready);
    // Next byte is taken together with the final result of the current one
    assign byte_ready = (state_reg == S_WAIT) || (fire && sts.emit_last);
    assign accept     = byte_valid && byte_ready;

    assign cmd.cap  = accept;
    assign cmd.proc = (state_reg == S_PROC);
    assign cmd.emit = fire;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_WAIT:
            begin
                if (accept)
                    state_next = S_PROC;
            end
            S_PROC:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (fire && sts.emit_last)
                    state_next = accept ? S_PROC : S_WAIT;
            end
            default:
            begin
                state_next = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_WAIT;
        else
            state_reg <= state_next;
    end

endmodule

FILE: sv/prd_dp.sv
module prd_dp
#(
    parameter int SIZE_BITS         = prd_pkg::SIZE_BITS_DEF,
    parameter int PIXELS_PER_RESULT = prd_pkg::PIX_PER_RES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  prd_pkg::cmd_t        cmd,
    output prd_pkg::sts_t        sts,
    input  prd_pkg::in_t         byte_data,
    input  logic                 rgba_mode,
    input  logic [((SIZE_BITS < prd_pkg::IMG_W) ? SIZE_BITS : prd_pkg::IMG_W)-1:0] image_bytes,
    input  logic                 pix_ready,
    output logic                 pix_valid,
    output prd_pkg::out_t        pix_data
);

    localparam int CNT_W = (SIZE_BITS < prd_pkg::IMG_W) ? SIZE_BITS : prd_pkg::IMG_W;
    localparam int EXT_W = (CNT_W > 9) ? CNT_W : 9;
    localparam int PER   = (PIXELS_PER_RESULT > prd_pkg::SLOTS) ? prd_pkg::SLOTS :
                           ((PIXELS_PER_RESULT < 1) ? 1 : PIXELS_PER_RESULT);
    localparam logic [6:0] PER_PX = 7'(PER);
    localparam logic [prd_pkg::RES_IDX_W-1:0] LAST_IDX =
        prd_pkg::RES_IDX_W'(prd_pkg::MAX_RESULTS - 1);

    // Latched input byte
    logic [7:0]         byte_reg;
    logic               last_reg;

    // Stream state
    logic [1:0]         phase_reg,   phase_next;
    logic [6:0]         rem_reg,     rem_next;
    logic [1:0]         bip_reg,     bip_next;
    logic [31:0]        gather_reg,  gather_next;
    logic [CNT_W-1:0]   written_reg, written_next;
    logic               overrun_reg, overrun_next;

    // Flags reported with the results of the current byte
    logic               corrupt_reg, corrupt_next;
    logic               full_reg,    full_next;

    // Burst of results for the current byte
    logic [31:0]        bpix_reg,    bpix_next;
    logic [6:0]         bleft_reg,   bleft_next;
    logic [prd_pkg::RES_IDX_W-1:0] bidx_reg, bidx_next;

    // Output register
    logic               pvld_reg,    pvld_next;
    prd_pkg::out_t      pdata_reg,   pdata_next;

    // Decode helpers
    logic [6:0]         cnt_n;
    logic [8:0]         need;
    logic [CNT_W-1:0]   room;
    logic [EXT_W-1:0]   room_ext;
    logic               over;
    logic [16:0]        div3_prod;
    logic [6:0]         room_px;
    logic [31:0]        gather_new;
    logic               px_done;
    logic [8:0]         run_bytes;
    logic [CNT_W-1:0]   written_inc;
    logic               lit_full;
    logic [6:0]         rem_dec;
    logic               active;

    // Emit helpers
    logic [2:0]         slot_cnt;
    logic               emit_last;

    assign cnt_n      = byte_reg[6:0];
    assign need       = rgba_mode ? {cnt_n, 2'b00} : ({2'b00, cnt_n} + {1'b0, cnt_n, 1'b0});
    assign room       = image_bytes - written_reg;
    assign room_ext   = EXT_W'(room);
    assign over       = EXT_W'(need) > room_ext;
    // room / 3 by reciprocal; exact for room below 512, which holds when over
    assign div3_prod  = 17'(room_ext[8:0]) * 17'd171;
    assign room_px    = rgba_mode ? room_ext[8:2] : div3_prod[15:9];
    assign gather_new = gather_reg | (32'(byte_reg) << {bip_reg, 3'b000});
    assign px_done    = rgba_mode ? (bip_reg == 2'd3) : (bip_reg == 2'd2);
    assign run_bytes  = rgba_mode ? {rem_reg, 2'b00}
                                  : ({2'b00, rem_reg} + {1'b0, rem_reg, 1'b0});
    assign written_inc = written_reg + CNT_W'(1);
    assign lit_full   = (written_inc == image_bytes);
    assign rem_dec    = rem_reg - 7'd1;
    assign active     = written_reg < image_bytes;

    assign slot_cnt   = (bleft_reg > PER_PX) ? 3'(PER) : bleft_reg[2:0];
    assign emit_last  = (bleft_reg <= PER_PX) || (bidx_reg == LAST_IDX);

    assign sts.emit_last = emit_last;
    assign sts.out_busy  = pvld_reg;

    // Byte decode, burst load and emit
    always_comb
    begin
        phase_next   = phase_reg;
        rem_next     = rem_reg;
        bip_next     = bip_reg;
        gather_next  = gather_reg;
        written_next = written_reg;
        overrun_next = overrun_reg;
        corrupt_next = corrupt_reg;
        full_next    = full_reg;
        bpix_next    = bpix_reg;
        bleft_next   = bleft_reg;
        bidx_next    = bidx_reg;
        pvld_next    = pvld_reg;
        pdata_next   = pdata_reg;

        if (cmd.proc)
        begin
            bpix_next  = gather_new;
            bleft_next = 7'd0;
            bidx_next  = '0;

            if (active)
            begin
                case (phase_reg)
                    prd_pkg::PH_COUNT:
                    begin
                        bip_next    = 2'd0;
                        gather_next = 32'd0;
                        if (byte_reg[7])
                        begin
                            if (over)
                                overrun_next = 1'b1;
                            rem_next   = over ? room_px : cnt_n;
                            phase_next = prd_pkg::PH_RUN;
                        end
                        else if (cnt_n != 7'd0)
                        begin
                            if (over)
                                overrun_next = 1'b1;
                            rem_next   = cnt_n;
                            phase_next = prd_pkg::PH_LIT;
                        end
                    end
                    prd_pkg::PH_RUN:
                    begin
                        gather_next = gather_new;
                        bip_next    = bip_reg + 2'd1;
                        if (px_done)
                        begin
                            bleft_next   = rem_reg;
                            written_next = written_reg + CNT_W'(run_bytes);
                            rem_next     = 7'd0;
                            bip_next     = 2'd0;
                            gather_next  = 32'd0;
                            phase_next   = prd_pkg::PH_COUNT;
                        end
                    end
                    default:
                    begin
                        // literal packet
                        gather_next  = gather_new;
                        bip_next     = bip_reg + 2'd1;
                        written_next = written_inc;
                        if (px_done || lit_full)
                            bleft_next = 7'd1;
                        if (px_done)
                        begin
                            bip_next    = 2'd0;
                            gather_next = 32'd0;
                            rem_next    = rem_dec;
                            if (rem_dec == 7'd0)
                                phase_next = prd_pkg::PH_COUNT;
                        end
                        if (lit_full)
                        begin
                            bip_next    = 2'd0;
                            gather_next = 32'd0;
                            rem_next    = 7'd0;
                            phase_next  = prd_pkg::PH_COUNT;
                        end
                    end
                endcase
            end

            if (last_reg && (phase_next != prd_pkg::PH_COUNT))
                overrun_next = 1'b1;

            corrupt_next = overrun_next;
            full_next    = written_next >= image_bytes;

            // end of stream: back to start state
            if (last_reg)
            begin
                phase_next   = prd_pkg::PH_COUNT;
                rem_next     = 7'd0;
                bip_next     = 2'd0;
                gather_next  = 32'd0;
                written_next = '0;
                overrun_next = 1'b0;
            end
        end

        // Output register drain and load
        if (pix_ready)
            pvld_next = 1'b0;

        if (cmd.emit)
        begin
            pvld_next              = 1'b1;
            pdata_next.pixel_a     = (slot_cnt > 3'd0) ? bpix_reg : 32'd0;
            pdata_next.pixel_b     = (slot_cnt > 3'd1) ? bpix_reg : 32'd0;
            pdata_next.pixel_c     = (slot_cnt > 3'd2) ? bpix_reg : 32'd0;
            pdata_next.pixel_d     = (slot_cnt > 3'd3) ? bpix_reg : 32'd0;
            pdata_next.pixel_count = slot_cnt;
            pdata_next.corrupt     = corrupt_reg;
            pdata_next.image_full  = full_reg;
            pdata_next.run_last    = emit_last;
            bleft_next             = bleft_reg - 7'(slot_cnt);
            bidx_next              = bidx_reg + prd_pkg::RES_IDX_W'(1);
        end
    end

    // Input byte latch
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            byte_reg <= byte_data.data_byte;
            last_reg <= byte_data.stream_last;
        end
    end

    // Control and stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= prd_pkg::PH_COUNT;
            rem_reg     <= 7'd0;
            bip_reg     <= 2'd0;
            gather_reg  <= 32'd0;
            written_reg <= '0;
            overrun_reg <= 1'b0;
            bleft_reg   <= 7'd0;
            bidx_reg    <= '0;
            pvld_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            rem_reg     <= rem_next;
            bip_reg     <= bip_next;
            gather_reg  <= gather_next;
            written_reg <= written_next;
            overrun_reg <= overrun_next;
            bleft_reg   <= bleft_next;
            bidx_reg    <= bidx_next;
            pvld_reg    <= pvld_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        corrupt_reg <= corrupt_next;
        full_reg    <= full_next;
        bpix_reg    <= bpix_next;
        pdata_reg   <= pdata_next;
    end

    assign pix_valid = pvld_reg;
    assign pix_data  = pdata_reg;

endmodule
